[src/rmpp_pkg.sv]
package rmpp_pkg;

	// Fixed field widths
	localparam int CHAN_W     = 8;
	localparam int WORD_W     = 32;
	localparam int ADDR_W     = 28;
	localparam int BPP_W      = 3;
	localparam int PITCH_W    = 16;
	localparam int DIM_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	// Wide enough to hold any 13-bit frame dimension (up to 8191)
	localparam int DIM_CALC_W = 17;

	// Default geometry limits
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Register reset values
	localparam logic [WORD_W-1:0]  RED_MASK_RST     = 32'h00FF_0000;
	localparam logic [WORD_W-1:0]  GREEN_MASK_RST   = 32'h0000_FF00;
	localparam logic [WORD_W-1:0]  BLUE_MASK_RST    = 32'h0000_00FF;
	localparam logic [BPP_W-1:0]   BPP_RST          = 3'd4;
	localparam logic [PITCH_W-1:0] ROW_PITCH_RST    = 16'd4096;
	localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 13'd1024;
	localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 13'd1024;

	// Pixel size codes
	localparam logic [BPP_W-1:0] BPP_ONE   = 3'd1;
	localparam logic [BPP_W-1:0] BPP_TWO   = 3'd2;
	localparam logic [BPP_W-1:0] BPP_THREE = 3'd3;
	localparam logic [BPP_W-1:0] BPP_FOUR  = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RED_MASK     = 3'd0,
		CFG_GREEN_MASK   = 3'd1,
		CFG_BLUE_MASK    = 3'd2,
		CFG_BPP          = 3'd3,
		CFG_ROW_PITCH    = 3'd4,
		CFG_IMAGE_WIDTH  = 3'd5,
		CFG_IMAGE_HEIGHT = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pix_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] pixel_word;
		logic [ADDR_W-1:0] byte_address;
		logic [BPP_W-1:0]  byte_count;
		logic              row_end;
		logic              frame_end;
	} res_beat_t;

	// Effective format settings (pixel size already forced into 1..4)
	typedef struct packed {
		logic [WORD_W-1:0]  red_mask;
		logic [WORD_W-1:0]  green_mask;
		logic [WORD_W-1:0]  blue_mask;
		logic [BPP_W-1:0]   bpp;
		logic [PITCH_W-1:0] row_pitch;
	} fmt_cfg_t;

	// Raster position of the pixel being accepted
	typedef struct packed {
		logic [ADDR_W-1:0] byte_address;
		logic              row_end;
		logic              frame_end;
	} pos_t;

endpackage

[src/rgb888_to_masked_pixel_packer.sv]
// RGB888 to masked pixel packer.
// Input channel (pix_valid / pix_stall / pix_data): one beat per source pixel,
// blue, green, red bytes, in raster order. Output channel (res_valid /
// res_stall / res_data): one beat per input beat, in the same order, with the
// packed pixel word, its byte address in the surface, byte count and
// end-of-row / end-of-frame marks.
// Configuration port (cfg_we / cfg_index / cfg_data): write-only registers
// for the three channel masks, pixel size, row pitch, width and height.
// Write them only while no beat is in flight.
// Stage 1 captures the pixel with its raster position and address; stage 2
// holds the packed result. Throughput: one beat per cycle while res_stall is
// low, set by the two pipeline registers; the raster counter advances once
// per accepted beat.
// Stall: res_stall holds stage 2; stage 1 keeps taking a beat while stage 2
// is full but draining, and pix_stall rises only when both stages are full
// and the receiver stalls.
// Reset: arst_n clears the pipeline valids, the raster position (row 0,
// column 0) and loads the default register values (8:8:8 in 32-bit words,
// 4096-byte pitch, 1024x1024 frame).
module rgb888_to_masked_pixel_packer #(
	parameter int MAX_WIDTH  = rmpp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rmpp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  rmpp_pkg::pix_beat_t              pix_data,
	output logic                             res_valid,
	input  logic                             res_stall,
	output rmpp_pkg::res_beat_t              res_data,
	input  logic                             cfg_we,
	input  logic [rmpp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rmpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rmpp_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	fmt_cfg_t          fmt;
	logic [COL_W-1:0]  last_col;
	logic [ROW_W-1:0]  last_row;
	pos_t              pos;
	logic              pix_accept;

	// pipeline state
	logic              valid_s1;
	pix_beat_t         pix_s1;
	pos_t              pos_s1;
	logic              valid_s2;
	res_beat_t         res_s2;
	logic              stall_s1;
	logic              stall_s2;
	logic              adv_s2;
	logic [WORD_W-1:0] packed_word;

	rmpp_cfg_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W),
		.ROW_W      (ROW_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fmt       (fmt),
		.last_col  (last_col),
		.last_row  (last_row)
	);

	// raster position steps once per accepted beat
	rmpp_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W),
		.ROW_W      (ROW_W)
	) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (pix_accept),
		.last_col  (last_col),
		.last_row  (last_row),
		.bpp       (fmt.bpp),
		.row_pitch (fmt.row_pitch),
		.pos       (pos)
	);

	// stage 2 pixel formatting from the stage 1 pixel
	rmpp_pack u_pack (
		.pix        (pix_s1),
		.fmt        (fmt),
		.pixel_word (packed_word)
	);

	// stall chain: a stage holds only when it is full and the next one holds
	assign stall_s2   = valid_s2 && res_stall;
	assign stall_s1   = valid_s1 && stall_s2;
	assign adv_s2     = valid_s1 && !stall_s2;
	assign pix_stall  = stall_s1;
	assign pix_accept = pix_valid && !stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!stall_s1) begin
				valid_s1 <= pix_valid;
			end
			if (!stall_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			pix_s1 <= pix_data;
			pos_s1 <= pos;
		end
		if (adv_s2) begin
			res_s2.pixel_word   <= packed_word;
			res_s2.byte_address <= pos_s1.byte_address;
			res_s2.byte_count   <= fmt.bpp;
			res_s2.row_end      <= pos_s1.row_end;
			res_s2.frame_end    <= pos_s1.frame_end;
		end
	end

	assign res_valid = valid_s2;
	assign res_data  = res_s2;

endmodule

[src/rmpp_cfg_regs.sv]
module rmpp_cfg_regs #(
	parameter int MAX_WIDTH  = rmpp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rmpp_pkg::DEF_MAX_HEIGHT,
	parameter int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	parameter int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rmpp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rmpp_pkg::CFG_DATA_W-1:0]      cfg_data,
	output rmpp_pkg::fmt_cfg_t                   fmt,
	output logic [COL_W-1:0]                     last_col,
	output logic [ROW_W-1:0]                     last_row
);
	import rmpp_pkg::*;

	logic [WORD_W-1:0]     red_mask_q;
	logic [WORD_W-1:0]     green_mask_q;
	logic [WORD_W-1:0]     blue_mask_q;
	logic [BPP_W-1:0]      bpp_q;
	logic [PITCH_W-1:0]    row_pitch_q;
	logic [DIM_W-1:0]      width_q;
	logic [DIM_W-1:0]      height_q;
	logic [BPP_W-1:0]      bpp_eff;
	logic [DIM_CALC_W-1:0] w_ext;
	logic [DIM_CALC_W-1:0] h_ext;
	logic [DIM_CALC_W-1:0] w_last;
	logic [DIM_CALC_W-1:0] h_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_mask_q   <= RED_MASK_RST;
			green_mask_q <= GREEN_MASK_RST;
			blue_mask_q  <= BLUE_MASK_RST;
			bpp_q        <= BPP_RST;
			row_pitch_q  <= ROW_PITCH_RST;
			width_q      <= IMAGE_WIDTH_RST;
			height_q     <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RED_MASK:     red_mask_q   <= cfg_data[WORD_W-1:0];
				CFG_GREEN_MASK:   green_mask_q <= cfg_data[WORD_W-1:0];
				CFG_BLUE_MASK:    blue_mask_q  <= cfg_data[WORD_W-1:0];
				CFG_BPP:          bpp_q        <= cfg_data[BPP_W-1:0];
				CFG_ROW_PITCH:    row_pitch_q  <= cfg_data[PITCH_W-1:0];
				CFG_IMAGE_WIDTH:  width_q      <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: height_q     <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// size 0 behaves as 1, sizes above 4 behave as 4
	always_comb begin
		if (bpp_q == '0) begin
			bpp_eff = BPP_ONE;
		end else if (bpp_q > BPP_FOUR) begin
			bpp_eff = BPP_FOUR;
		end else begin
			bpp_eff = bpp_q;
		end
	end

	// last column/row index with 0 -> 1 and clamp to the build-time maximum
	always_comb begin
		w_ext = DIM_CALC_W'(width_q);
		h_ext = DIM_CALC_W'(height_q);
		if (w_ext == '0) begin
			w_last = '0;
		end else if (w_ext > DIM_CALC_W'(MAX_WIDTH)) begin
			w_last = DIM_CALC_W'(MAX_WIDTH - 1);
		end else begin
			w_last = w_ext - 1'b1;
		end
		if (h_ext == '0) begin
			h_last = '0;
		end else if (h_ext > DIM_CALC_W'(MAX_HEIGHT)) begin
			h_last = DIM_CALC_W'(MAX_HEIGHT - 1);
		end else begin
			h_last = h_ext - 1'b1;
		end
	end

	assign last_col = w_last[COL_W-1:0];
	assign last_row = h_last[ROW_W-1:0];

	assign fmt.red_mask   = red_mask_q;
	assign fmt.green_mask = green_mask_q;
	assign fmt.blue_mask  = blue_mask_q;
	assign fmt.bpp        = bpp_eff;
	assign fmt.row_pitch  = row_pitch_q;

endmodule

[src/rmpp_raster.sv]
module rmpp_raster #(
	parameter int MAX_WIDTH  = rmpp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rmpp_pkg::DEF_MAX_HEIGHT,
	parameter int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	parameter int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [COL_W-1:0]              last_col,
	input  logic [ROW_W-1:0]              last_row,
	input  logic [rmpp_pkg::BPP_W-1:0]    bpp,
	input  logic [rmpp_pkg::PITCH_W-1:0]  row_pitch,
	output rmpp_pkg::pos_t                pos
);
	import rmpp_pkg::*;

	localparam int PROD_W = COL_W + BPP_W;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] row_start_q;
	logic [PROD_W-1:0] col_offset;
	logic              row_end;
	logic              frame_end;

	// column * pixel size, small multiply
	assign col_offset = PROD_W'(col_q) * PROD_W'(bpp);

	// at or beyond the last index counts as the last one
	assign row_end   = (col_q >= last_col);
	assign frame_end = row_end && (row_q >= last_row);

	assign pos.byte_address = row_start_q + ADDR_W'(col_offset);
	assign pos.row_end      = row_end;
	assign pos.frame_end    = frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			row_start_q <= '0;
		end else if (advance) begin
			if (frame_end) begin
				col_q       <= '0;
				row_q       <= '0;
				row_start_q <= '0;
			end else if (row_end) begin
				col_q       <= '0;
				row_q       <= row_q + 1'b1;
				row_start_q <= row_start_q + ADDR_W'(row_pitch);
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

[src/rmpp_pack.sv]
module rmpp_pack (
	input  rmpp_pkg::pix_beat_t          pix,
	input  rmpp_pkg::fmt_cfg_t           fmt,
	output logic [rmpp_pkg::WORD_W-1:0]  pixel_word
);
	import rmpp_pkg::*;

	logic [WORD_W-1:0] merged;

	// Top-align the byte under the mask's highest set bit, then mask.
	// A zero mask gives zero through the final AND.
	function automatic logic [WORD_W-1:0] place_channel(
		input logic [CHAN_W-1:0] chan,
		input logic [WORD_W-1:0] mask
	);
		logic [4:0]        top;
		logic [WORD_W-1:0] word;
		top = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (mask[i]) begin
				top = 5'(i);
			end
		end
		word = {chan, 24'd0} >> (5'd31 - top);
		return word & mask;
	endfunction

	assign merged = place_channel(pix.blue, fmt.blue_mask)
	              | place_channel(pix.green, fmt.green_mask)
	              | place_channel(pix.red, fmt.red_mask);

	// bytes at and above the pixel size are dropped
	always_comb begin
		case (fmt.bpp)
			BPP_ONE:   pixel_word = merged & 32'h0000_00FF;
			BPP_TWO:   pixel_word = merged & 32'h0000_FFFF;
			BPP_THREE: pixel_word = merged & 32'h00FF_FFFF;
			default:   pixel_word = merged;
		endcase
	end

endmodule

[src/rmpp_checker.sv]
module rmpp_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	input  logic                             pix_stall,
	input  logic                             res_valid,
	input  logic                             res_stall,
	input  rmpp_pkg::res_beat_t              res_data
);
	import rmpp_pkg::*;

	logic       in_take;
	logic       out_take;
	logic [2:0] inflight_q;
	logic       frame_start_q;

	assign in_take  = pix_valid && !pix_stall;
	assign out_take = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q    <= '0;
			frame_start_q <= 1'b1;
		end else begin
			inflight_q <= inflight_q + 3'(in_take) - 3'(out_take);
			if (out_take) begin
				frame_start_q <= res_data.frame_end;
			end
		end
	end

	// held output beat stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("output beat changed while stalled");

	// no result without a pixel that caused it, at most two in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> inflight_q != 3'd0)
		else $error("output beat without a matching input beat");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2)
		else $error("more beats in flight than pipeline stages");

	// input stalls only when the output side is full and held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("input stalled with output free");

	// first pixel of a frame sits at surface offset zero
	a_frame_origin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_start_q |-> res_data.byte_address == '0)
		else $error("frame does not start at address zero");

endmodule

bind rgb888_to_masked_pixel_packer rmpp_checker u_rmpp_checker (.*);
